FILE: src/ghsp_pkg.sv
package ghsp_pkg;

	localparam int MAX_SIDE_DEF = 16;
	localparam int HEIGHT_BITS_DEF = 4;
	localparam int DIST_BITS = 12;
	localparam logic [DIST_BITS-1:0] DIST_ALL_ONES = '1;
	localparam int GRID_BITS = 5;
	localparam logic [GRID_BITS-1:0] GRID_RESET = 5'd16;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_RUN  = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SCAN,
		ST_PICK,
		ST_NB_RD,
		ST_NB_WR,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_READ,
		ST_OUT
	} state_t;

endpackage

FILE: src/ghsp_if.sv
interface ghsp_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [3:0] row;
	logic [3:0] col;
	logic [3:0] height;
	modport source(output valid, opcode, row, col, height, input ready);
	modport sink(input valid, opcode, row, col, height, output ready);
endinterface

interface ghsp_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] distance;
	logic        status;
	modport source(output valid, distance, status, input ready);
	modport sink(input valid, distance, status, output ready);
endinterface

FILE: src/ghsp_core.sv
// sequencer with one abs-difference/add unit for relaxation; tentative distances and visited marks share a memory
module ghsp_core
	import ghsp_pkg::*;
#(
	parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           opcode,
	input  logic [3:0]           row,
	input  logic [3:0]           col,
	input  logic [3:0]           height,
	input  logic [GRID_BITS-1:0] grid_size,
	output logic                 busy,
	output logic                 done,
	output logic [DIST_BITS-1:0] distance,
	output logic                 status
);
	localparam int MAX_SIDE = MAX_SIDE_DEF;
	localparam int CELLS = MAX_SIDE * MAX_SIDE;
	localparam int SB = $clog2(MAX_SIDE);
	localparam int AB = 2 * SB;
	localparam int TB = DIST_BITS + 2;
	localparam int TW = TB + 1;
	localparam logic [TB-1:0] TNONE = '1;

	state_t state_q, state_d;
	logic [HEIGHT_BITS-1:0] hmem [CELLS];
	// word: visited mark on top of the tentative distance
	logic [TW-1:0] tmem [CELLS];
	logic [DIST_BITS-1:0] dmem [CELLS];
	logic [CELLS-1:0] dvalid_q;

	logic [AB:0] idx_q;
	logic [AB-1:0] cur_q, best_q;
	logic [TB-1:0] bestd_q, curd_q;
	logic found_q;
	logic [HEIGHT_BITS-1:0] curh_q;
	logic [2:0] nb_q;
	logic [SB:0] n_q;
	logic [DIST_BITS-1:0] dist_q;
	logic stat_q;
	logic [TW-1:0] t_rd_q;
	logic [HEIGHT_BITS-1:0] h_rd_q;
	logic [DIST_BITS-1:0] d_rd_q;
	logic [AB-1:0] nb_addr_q;

	logic [SB:0] n_in;
	logic [AB-1:0] in_addr;
	logic in_bad;
	logic [AB-1:0] idx_a;
	logic [SB-1:0] cr, cc;
	logic nb_ok;
	logic [AB-1:0] nb_addr;
	logic [HEIGHT_BITS-1:0] hdiff;
	logic [TB-1:0] nd;
	logic rd_vis;
	logic [TB-1:0] rd_tent;
	logic scan_hit;
	logic relax_hit;

	assign n_in = (grid_size > GRID_BITS'(MAX_SIDE)) ? (SB+1)'(MAX_SIDE)
		: (SB+1)'(grid_size);
	assign in_bad = ({1'b0, row} >= 5'(n_in)) || ({1'b0, col} >= 5'(n_in));
	assign in_addr = AB'({SB'(row), SB'(col)});
	assign idx_a = idx_q[AB-1:0];
	assign cr = cur_q[AB-1:SB];
	assign cc = cur_q[SB-1:0];
	assign rd_vis = t_rd_q[TB];
	assign rd_tent = t_rd_q[TB-1:0];
	// a cell is on the frontier when it has a distance and is not yet visited
	assign scan_hit = idx_q != '0 && !rd_vis && rd_tent != TNONE
		&& (!found_q || rd_tent < bestd_q);

	always_comb begin
		nb_ok = 1'b0;
		nb_addr = cur_q;
		unique case (nb_q[1:0])
			2'd0: begin
				nb_ok = cr != '0;
				nb_addr = cur_q - AB'(MAX_SIDE);
			end
			2'd1: begin
				nb_ok = ({1'b0, cr} + 1'b1) < n_q;
				nb_addr = cur_q + AB'(MAX_SIDE);
			end
			2'd2: begin
				nb_ok = cc != '0;
				nb_addr = cur_q - 1'b1;
			end
			default: begin
				nb_ok = ({1'b0, cc} + 1'b1) < n_q;
				nb_addr = cur_q + 1'b1;
			end
		endcase
	end

	// relaxation unit: abs difference and add
	assign hdiff = (curh_q > h_rd_q) ? curh_q - h_rd_q : h_rd_q - curh_q;
	assign nd = curd_q + TB'(hdiff);
	assign relax_hit = !rd_vis && nd < rd_tent;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) begin
				if (in_bad || opcode == OP_LOAD || opcode == OP_NONE) state_d = ST_OUT;
				else if (opcode == OP_RUN) state_d = ST_CLEAR;
				else state_d = ST_READ;
			end
			ST_CLEAR: if (idx_q == (AB+1)'(CELLS - 1)) state_d = ST_SCAN;
			ST_SCAN: if (idx_q == (AB+1)'(CELLS)) state_d = ST_PICK;
			ST_PICK: state_d = found_q ? ST_NB_RD : ST_COPY_RD;
			ST_NB_RD: if (nb_q[2]) state_d = ST_SCAN;
				else if (nb_ok) state_d = ST_NB_WR;
			ST_NB_WR: state_d = ST_NB_RD;
			ST_COPY_RD: state_d = ST_COPY_WR;
			ST_COPY_WR: state_d = (idx_q == (AB+1)'(CELLS)) ? ST_OUT : ST_COPY_RD;
			ST_READ: state_d = ST_OUT;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = state_q != ST_IDLE;
		done = state_q == ST_OUT;
		distance = dist_q;
		status = stat_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dvalid_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
			nb_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: idx_q <= '0;
				ST_CLEAR: idx_q <= (state_d == ST_SCAN) ? '0 : idx_q + 1'b1;
				ST_SCAN: begin
					if (idx_q == '0) found_q <= 1'b0;
					if (idx_q != (AB+1)'(CELLS)) idx_q <= idx_q + 1'b1;
					if (scan_hit) found_q <= 1'b1;
				end
				ST_PICK: begin
					idx_q <= '0;
					nb_q <= '0;
				end
				ST_NB_RD: begin
					if (!nb_ok && !nb_q[2]) nb_q <= nb_q + 1'b1;
					if (nb_q[2]) idx_q <= '0;
				end
				ST_NB_WR: nb_q <= nb_q + 1'b1;
				ST_COPY_RD: idx_q <= idx_q + 1'b1;
				ST_COPY_WR: dvalid_q[nb_addr_q] <= 1'b1;
				default: ;
			endcase
		end
	end

	// datapath and memories
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (start) begin
				n_q <= n_in;
				stat_q <= in_bad && opcode != OP_NONE;
				dist_q <= '0;
				cur_q <= in_addr;
				if (!in_bad && opcode == OP_LOAD)
					hmem[in_addr] <= HEIGHT_BITS'(height);
			end
			ST_CLEAR: tmem[idx_a] <= {1'b0, (idx_a == cur_q) ? TB'(0) : TNONE};
			ST_SCAN: begin
				if (idx_q != (AB+1)'(CELLS)) begin
					t_rd_q <= tmem[idx_a];
					nb_addr_q <= idx_a;
				end
				if (scan_hit) begin
					bestd_q <= rd_tent;
					best_q <= nb_addr_q;
				end
			end
			ST_PICK: begin
				cur_q <= best_q;
				curd_q <= bestd_q;
				curh_q <= hmem[best_q];
				if (found_q) tmem[best_q] <= {1'b1, bestd_q};
			end
			ST_NB_RD: begin
				t_rd_q <= tmem[nb_addr];
				h_rd_q <= hmem[nb_addr];
				nb_addr_q <= nb_addr;
			end
			ST_NB_WR:
				if (relax_hit) tmem[nb_addr_q] <= {1'b0, nd};
			ST_COPY_RD: begin
				t_rd_q <= tmem[idx_a];
				nb_addr_q <= idx_a;
			end
			ST_COPY_WR:
				dmem[nb_addr_q] <= (rd_tent > TB'(DIST_ALL_ONES)) ? DIST_ALL_ONES
					: DIST_BITS'(rd_tent);
			ST_READ:
				dist_q <= dvalid_q[nb_addr_q] ? d_rd_q : DIST_ALL_ONES;
			default: ;
		endcase
		if (state_q == ST_IDLE && start) begin
			d_rd_q <= dmem[in_addr];
			nb_addr_q <= in_addr;
		end
	end

`ifndef NO_ASSERTIONS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |=> state_q == ST_IDLE) else $error("out not followed by idle");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> distance == '0) else $error("error with distance");
	a_pick_nb: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PICK && found_q |=> state_q == ST_NB_RD)
		else $error("pick not followed by neighbour read");
`endif
endmodule

FILE: src/grid_height_shortest_path.sv
// Height-grid shortest path: load (op 0), run (op 1) and read (op 2) each give one result.
// A load, an error or an unknown op goes straight to the output state, a read through ST_READ first.
// A run clears the tentative memory, then per selected cell scans all CELLS entries through
// one memory read port and relaxes its neighbours, then makes one last scan and a copy of
// CELLS distances. Not ready while busy or while a result waits.
module grid_height_shortest_path
	import ghsp_pkg::*;
#(
	parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [GRID_BITS-1:0] cfg_wdata,
	ghsp_in_if.sink req,
	ghsp_out_if.source rsp
);
	logic [GRID_BITS-1:0] grid_q;
	logic busy, done, start, status, out_v_q, stat_q;
	logic [DIST_BITS-1:0] distance, dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) grid_q <= GRID_RESET;
		else if (cfg_we) grid_q <= cfg_wdata;
	end

	assign req.ready = !busy && !out_v_q;
	assign start = req.valid && req.ready;

	ghsp_core #(.HEIGHT_BITS(HEIGHT_BITS)) u_core (
		.clk(clk), .arst_n(arst_n), .start(start), .opcode(req.opcode),
		.row(req.row), .col(req.col), .height(req.height), .grid_size(grid_q),
		.busy(busy), .done(done), .distance(distance), .status(status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (done) out_v_q <= 1'b1;
		else if (rsp.ready) out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) if (done) begin
		dist_q <= distance;
		stat_q <= status;
	end

	assign rsp.valid = out_v_q;
	assign rsp.distance = dist_q;
	assign rsp.status = stat_q;
endmodule
